FILE: rtl/q2e_pkg.sv
`default_nettype none
package q2e_pkg;

    // Q2.14 one and its Q4.28 square
    localparam int ONE_Q14 = 16384;
    localparam logic signed [35:0] ONE_Q28 = 36'sd268435456;

    // CORDIC datapath widths and depth
    localparam int CW = 28;
    localparam int ZW = 25;
    localparam int STEPS = 16;
    localparam logic signed [ZW-1:0] ANG_QUARTER = 25'sd2304000;
    localparam logic signed [16:0] ANG_LIMIT = 17'sd18000;

    // isqrt result bits: floor(sqrt(2^44)) = 2^22
    localparam int RW = 23;

    // round Q4.28 to Q2.14 (halves up), saturate to 16 bits
    function automatic logic signed [15:0] to_q14(input logic signed [35:0] v);
        logic signed [35:0] t;
        t = (v + 36'sd8192) >>> 14;
        if (t > 36'sd32767)
            return 16'sh7FFF;
        else if (t < -36'sd32768)
            return 16'sh8000;
        else
            return t[15:0];
    endfunction

    // arctangent of 2^-i in 1/256 of a hundredth degree
    function automatic logic signed [ZW-1:0] atan_ent(input int i);
        unique case (i)
            0:       return 25'sd1152000;
            1:       return 25'sd680065;
            2:       return 25'sd359328;
            3:       return 25'sd182400;
            4:       return 25'sd91554;
            5:       return 25'sd45822;
            6:       return 25'sd22916;
            7:       return 25'sd11459;
            8:       return 25'sd5730;
            9:       return 25'sd2865;
            10:      return 25'sd1432;
            11:      return 25'sd716;
            12:      return 25'sd358;
            13:      return 25'sd179;
            14:      return 25'sd90;
            15:      return 25'sd45;
            default: return 25'sd0;
        endcase
    endfunction

endpackage
`default_nettype wire

FILE: rtl/quat_to_rotation_zyz_euler_core.sv
// Channel  | Handshake          | Payload
// request  | start in, busy out | quat_w, quat_x, quat_y, quat_z
// result   | done out           | rot_00 .. rot_22, angle_first_z, angle_mid_y, angle_last_z
//
// One request per cycle, every cycle; busy is held low.
// A request passes the input, product, matrix, r22 square and radicand registers,
// a 23-stage digit-by-digit isqrt of the acos sine term, then three parallel
// 16-stage CORDIC pipes with fold and output register; done marks its result.
// Reset clears only the valid chain; no request is in flight after reset.
// The receiver cannot stall, so the pipeline never stops.
`default_nettype none
module quat_to_rotation_zyz_euler_core
    import q2e_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    output logic                    busy,
    input  wire logic signed [15:0] quat_w,
    input  wire logic signed [15:0] quat_x,
    input  wire logic signed [15:0] quat_y,
    input  wire logic signed [15:0] quat_z,
    output logic                    done,
    output logic signed [15:0]      rot_00,
    output logic signed [15:0]      rot_01,
    output logic signed [15:0]      rot_02,
    output logic signed [15:0]      rot_10,
    output logic signed [15:0]      rot_11,
    output logic signed [15:0]      rot_12,
    output logic signed [15:0]      rot_20,
    output logic signed [15:0]      rot_21,
    output logic signed [15:0]      rot_22,
    output logic signed [15:0]      angle_first_z,
    output logic [14:0]             angle_mid_y,
    output logic signed [15:0]      angle_last_z
);

    localparam int NV = 46;
    localparam int MD = 43;

    logic [NV-1:0] vld_reg;
    logic signed [15:0] qw_reg, qx_reg, qy_reg, qz_reg;
    logic signed [31:0] p_reg [9];
    logic signed [15:0] m_reg [9];
    logic signed [15:0] m_dly_reg [MD][9];
    logic signed [15:0] c_reg;
    logic [28:0] csq_reg;
    logic [47:0] sr_rem_reg [RW+1];
    logic [RW-1:0] sr_root_reg [RW+1];
    logic signed [15:0] sr_c_reg [RW+1];
    logic signed [CW-1:0] cx_reg [3][STEPS+1];
    logic signed [CW-1:0] cy_reg [3][STEPS+1];
    logic signed [ZW-1:0] cz_reg [3][STEPS+1];
    logic cnul_reg [3][STEPS+1];
    logic signed [CW-1:0] ax [3];
    logic signed [CW-1:0] ay [3];
    logic signed [16:0] h [3];
    logic signed [16:0] hc [3];
    logic signed [15:0] ang0_reg, ang2_reg;
    logic [14:0] ang1_reg;
    logic signed [15:0] c_next;
    logic signed [35:0] e [9];

    assign busy = 1'b0;

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NV-2:0], start};
    end

    // Q4.28 entries from registered products
    always_comb
    begin
        e[0] = ONE_Q28 - 36'(p_reg[1]) * 2 - 36'(p_reg[2]) * 2;
        e[1] = (36'(p_reg[3]) - 36'(p_reg[4])) * 2;
        e[2] = (36'(p_reg[5]) + 36'(p_reg[6])) * 2;
        e[3] = (36'(p_reg[3]) + 36'(p_reg[4])) * 2;
        e[4] = ONE_Q28 - 36'(p_reg[0]) * 2 - 36'(p_reg[2]) * 2;
        e[5] = (36'(p_reg[7]) - 36'(p_reg[8])) * 2;
        e[6] = (36'(p_reg[5]) - 36'(p_reg[6])) * 2;
        e[7] = (36'(p_reg[7]) + 36'(p_reg[8])) * 2;
        e[8] = ONE_Q28 - 36'(p_reg[0]) * 2 - 36'(p_reg[1]) * 2;
    end

    // clamp r22 to [-1, 1]
    always_comb
    begin
        if (m_reg[8] > 16'sd16384)
            c_next = 16'sd16384;
        else if (m_reg[8] < -16'sd16384)
            c_next = -16'sd16384;
        else
            c_next = m_reg[8];
    end

    // input, product, matrix, square and radicand stages, and the matrix delay line
    always_ff @(posedge clk)
    begin
        qw_reg <= quat_w;
        qx_reg <= quat_x;
        qy_reg <= quat_y;
        qz_reg <= quat_z;
        p_reg[0] <= qx_reg * qx_reg;
        p_reg[1] <= qy_reg * qy_reg;
        p_reg[2] <= qz_reg * qz_reg;
        p_reg[3] <= qx_reg * qy_reg;
        p_reg[4] <= qw_reg * qz_reg;
        p_reg[5] <= qx_reg * qz_reg;
        p_reg[6] <= qw_reg * qy_reg;
        p_reg[7] <= qy_reg * qz_reg;
        p_reg[8] <= qw_reg * qx_reg;
        for (int k = 0; k < 9; k++)
            m_reg[k] <= to_q14(e[k]);
        c_reg <= c_next;
        csq_reg <= 29'(32'(c_next) * 32'(c_next));
        sr_rem_reg[0] <= 48'(29'd268435456 - csq_reg) << 16;
        sr_root_reg[0] <= '0;
        sr_c_reg[0] <= c_reg;
        m_dly_reg[0] <= m_reg;
        for (int j = 1; j < MD; j++)
            m_dly_reg[j] <= m_dly_reg[j-1];
    end

    // isqrt, one result bit per stage, MSB first
    for (genvar k = 0; k < RW; k++) begin : g_sqrt
        localparam int B = RW - 1 - k;
        logic [47:0] trial;
        assign trial = (48'(sr_root_reg[k]) << (B + 1)) + (48'd1 << (2 * B));
        always_ff @(posedge clk)
        begin
            sr_c_reg[k+1] <= sr_c_reg[k];
            if (sr_rem_reg[k] >= trial)
            begin
                sr_rem_reg[k+1] <= sr_rem_reg[k] - trial;
                sr_root_reg[k+1] <= sr_root_reg[k] | (RW'(1) << B);
            end
            else
            begin
                sr_rem_reg[k+1] <= sr_rem_reg[k];
                sr_root_reg[k+1] <= sr_root_reg[k];
            end
        end
    end

    // CORDIC arguments: first, middle, last angle
    always_comb
    begin
        ay[0] = CW'(m_dly_reg[24][5]) <<< 8;
        ax[0] = CW'(m_dly_reg[24][2]) <<< 8;
        ay[1] = CW'($signed({1'b0, sr_root_reg[RW]}));
        ax[1] = CW'(sr_c_reg[RW]) <<< 8;
        ay[2] = CW'(m_dly_reg[24][7]) <<< 8;
        ax[2] = -(CW'(m_dly_reg[24][6]) <<< 8);
    end

    for (genvar ch = 0; ch < 3; ch++) begin : g_ch
        // quadrant fold into the right half plane
        always_ff @(posedge clk)
        begin
            cnul_reg[ch][0] <= (ax[ch] == '0) && (ay[ch] == '0);
            if (ax[ch] < 0)
            begin
                if (ay[ch] >= 0)
                begin
                    cx_reg[ch][0] <= ay[ch];
                    cy_reg[ch][0] <= -ax[ch];
                    cz_reg[ch][0] <= ANG_QUARTER;
                end
                else
                begin
                    cx_reg[ch][0] <= -ay[ch];
                    cy_reg[ch][0] <= ax[ch];
                    cz_reg[ch][0] <= -ANG_QUARTER;
                end
            end
            else
            begin
                cx_reg[ch][0] <= ax[ch];
                cy_reg[ch][0] <= ay[ch];
                cz_reg[ch][0] <= '0;
            end
        end

        // vectoring steps
        for (genvar i = 0; i < STEPS; i++) begin : g_step
            logic signed [CW-1:0] dx, dy;
            assign dx = cx_reg[ch][i] >>> i;
            assign dy = cy_reg[ch][i] >>> i;
            always_ff @(posedge clk)
            begin
                cnul_reg[ch][i+1] <= cnul_reg[ch][i];
                if (cy_reg[ch][i] >= 0)
                begin
                    cx_reg[ch][i+1] <= cx_reg[ch][i] + dy;
                    cy_reg[ch][i+1] <= cy_reg[ch][i] - dx;
                    cz_reg[ch][i+1] <= cz_reg[ch][i] + atan_ent(i);
                end
                else
                begin
                    cx_reg[ch][i+1] <= cx_reg[ch][i] - dy;
                    cy_reg[ch][i+1] <= cy_reg[ch][i] + dx;
                    cz_reg[ch][i+1] <= cz_reg[ch][i] - atan_ent(i);
                end
            end
        end

        // round to hundredths and clamp; a zero vector gives zero
        always_comb
        begin
            h[ch] = 17'((cz_reg[ch][STEPS] + ZW'(128)) >>> 8);
            if (cnul_reg[ch][STEPS])
                hc[ch] = '0;
            else if (h[ch] > ANG_LIMIT)
                hc[ch] = ANG_LIMIT;
            else if (h[ch] < -ANG_LIMIT)
                hc[ch] = -ANG_LIMIT;
            else
                hc[ch] = h[ch];
        end
    end

    // output registers
    always_ff @(posedge clk)
    begin
        ang0_reg <= hc[0][15:0];
        ang1_reg <= (hc[1] < 0) ? 15'd0 : hc[1][14:0];
        ang2_reg <= hc[2][15:0];
    end

    assign done = vld_reg[NV-1];
    assign rot_00 = m_dly_reg[MD-1][0];
    assign rot_01 = m_dly_reg[MD-1][1];
    assign rot_02 = m_dly_reg[MD-1][2];
    assign rot_10 = m_dly_reg[MD-1][3];
    assign rot_11 = m_dly_reg[MD-1][4];
    assign rot_12 = m_dly_reg[MD-1][5];
    assign rot_20 = m_dly_reg[MD-1][6];
    assign rot_21 = m_dly_reg[MD-1][7];
    assign rot_22 = m_dly_reg[MD-1][8];
    assign angle_first_z = ang0_reg;
    assign angle_mid_y = ang1_reg;
    assign angle_last_z = ang2_reg;

    // checks
    a_lat: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, NV))
        else $error("result without matching request");
    a_mid: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_mid_y <= 15'd18000))
        else $error("middle angle out of range");
    a_first: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (angle_first_z <= 16'sd18000 && angle_first_z >= -16'sd18000))
        else $error("first angle out of range");

endmodule
`default_nettype wire
